// ===== src/whm_pkg.sv =====
// Shared types and constants for the weighted histogram moments core.
package whm_pkg;

  localparam int ROWS   = 4;
  localparam int BINS   = 256;
  localparam int ROW_W  = 2;
  localparam int BIN_W  = 8;
  localparam int ADDR_W = ROW_W + BIN_W;
  localparam int NUSE_W = 9;
  localparam int DVS_W  = 42;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_STATS = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RANGE_LOW   = 2'd0,
    CFG_BIN_WIDTH   = 2'd1,
    CFG_BINS_IN_USE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_BCHK, S_BDIV, S_BWR, S_SINIT, S_WRD, S_WM1, S_WM2,
    S_WACC, S_FIN, S_MMUL, S_MDIV, S_VMUL1, S_VMUL2, S_VDIV1, S_VDIV2, S_VMUL3,
    S_VMUL4, S_RESP
  } state_t;

  typedef enum logic [4:0] {
    DC_NONE, DC_LOAD, DC_CLR_STEP, DC_RES_UNDER, DC_RES_OVER, DC_BIN_DIV,
    DC_BIN_RD, DC_BIN_WR, DC_STAT_INIT, DC_WALK_RD, DC_WALK_M1, DC_WALK_M2,
    DC_WALK_ACC, DC_MUL_MEAN, DC_DIV_MEAN, DC_SET_MEAN, DC_MUL_S1S1, DC_DIV_V1,
    DC_DIV_V2, DC_MUL_BW2, DC_MUL_VAR, DC_SET_VAR
  } dp_cmd_t;

  typedef struct packed {
    logic d_neg;
    logic bw_zero;
    logic ix_over;
    logic n_zero;
    logic last_bin;
    logic tw_zero;
    logic clr_last;
    logic mul_done;
    logic div_done;
  } dp_status_t;

endpackage

// ===== src/whm_mul.sv =====
// Sequential 64 x 64 multiplier, sixteen multiplier bits per cycle, low 128 bits kept.
module whm_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);
  import whm_pkg::*;

  logic [63:0]  a_r, a_nxt, b_r, b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [79:0]  part;

  assign part = a_r * b_r[63:48];

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt = a;
      b_nxt = b;
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Highest chunk first, so the running sum shifts up each step.
      acc_nxt = (acc_r << 16) + {48'd0, part};
      b_nxt = b_r << 16;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign prod = acc_r;
  assign done = done_r;
endmodule

// ===== src/whm_div.sv =====
// Restoring divider, one quotient bit per cycle over the top bits of a 128-bit dividend.
module whm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [127:0]               dvd,
  input  logic [whm_pkg::DVS_W-1:0]  dvs,
  input  logic [7:0]                 steps,
  output logic [127:0]               quo,
  output logic                       done
);
  import whm_pkg::*;

  logic [127:0]     n_r, n_nxt, q_r, q_nxt;
  logic [DVS_W-1:0] d_r, d_nxt, rem_r, rem_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, n_r[127]};
  assign ge = trial >= {1'b0, d_r};

  always_comb begin
    n_nxt = n_r;
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt = dvd;
      q_nxt = '0;
      d_nxt = dvs;
      rem_nxt = '0;
      cnt_nxt = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      q_nxt = {q_r[126:0], ge};
      rem_nxt = ge ? DVS_W'(trial - {1'b0, d_r}) : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo = q_r;
  assign done = done_r;
endmodule

// ===== src/whm_datapath.sv =====
// Datapath: configuration, bin memory, accumulators, arithmetic units and result register.
module whm_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  whm_pkg::dp_cmd_t            cmd,
  input  logic [whm_pkg::ROW_W-1:0]   in_row,
  input  logic [31:0]                 in_sample,
  input  logic [15:0]                 in_weight,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [31:0]                 cfg_val,
  output whm_pkg::dp_status_t         sts,
  output logic [1:0]                  res_status,
  output logic [39:0]                 res_sum,
  output logic [31:0]                 res_mean,
  output logic [47:0]                 res_var
);
  import whm_pkg::*;

  logic [31:0] mem [ROWS*BINS];
  logic [31:0] rd_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;

  logic [31:0] rl_r, bw_r;
  logic [NUSE_W-1:0] biu_r, nuse;
  logic [ROW_W-1:0] row_r;
  logic [31:0] smp_r;
  logic [15:0] wgt_r;
  logic [ADDR_W-1:0] clr_r;
  logic [BIN_W-1:0] idx_r;
  logic [31:0] w_r;
  logic [39:0] p1_r;
  logic [47:0] p2_r;
  logic [39:0] tw_r;
  logic [47:0] s1_r;
  logic [55:0] s2_r;
  logic [127:0] x_r;
  logic [1:0]  st_r;
  logic [31:0] mean_r;
  logic [47:0] var_r;
  logic [39:0] sum_r;

  logic [32:0] d;
  logic [32:0] bin_sum;
  logic [31:0] qb;
  logic [49:0] mean_num;
  logic [43:0] mean_full;
  logic [31:0] mean_sat;
  logic [47:0] var_sat;

  logic         mul_start, div_start;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_p, div_q, div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [7:0]   div_steps;
  logic         mul_done, div_done;

  whm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(mul_p), .done(mul_done)
  );

  whm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dvd(div_dvd), .dvs(div_dvs),
    .steps(div_steps), .quo(div_q), .done(div_done)
  );

  assign nuse = (biu_r > NUSE_W'(BINS)) ? NUSE_W'(BINS) : biu_r;
  assign d = {smp_r[31], smp_r} - {rl_r[31], rl_r};
  assign qb = div_q[31:0];
  assign bin_sum = {1'b0, rd_r} + {17'd0, wgt_r};
  assign mean_num = {s1_r, 1'b0} + {10'd0, tw_r};
  assign mean_full = {{12{rl_r[31]}}, rl_r} + {1'b0, div_q[42:0]};
  assign mean_sat = ($signed(mean_full) > $signed(44'sh0007FFFFFFF)) ? 32'h7FFFFFFF :
                    ($signed(mean_full) < $signed(-44'sh80000000)) ? 32'h80000000 :
                    mean_full[31:0];
  assign var_sat = (mul_p[127:96] != '0) ? {48{1'b1}} : mul_p[95:48];

  always_comb begin
    sts.d_neg = d[32];
    sts.bw_zero = (bw_r == '0);
    sts.ix_over = (qb[31:NUSE_W] != '0) || (qb[NUSE_W-1:0] >= nuse);
    sts.n_zero = (nuse == '0);
    sts.last_bin = ({1'b0, idx_r} == nuse - NUSE_W'(1));
    sts.tw_zero = (tw_r == '0);
    sts.clr_last = (clr_r == {ADDR_W{1'b1}});
    sts.mul_done = mul_done;
    sts.div_done = div_done;
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = {{(DVS_W-40){1'b0}}, tw_r};
    div_steps = 8'd128;
    rd_addr = {row_r, idx_r};
    wr_en = 1'b0;
    wr_addr = clr_r;
    wr_data = '0;
    unique case (cmd)
      DC_CLR_STEP: wr_en = 1'b1;
      DC_BIN_DIV: begin
        div_start = 1'b1;
        div_dvd = {d[31:0], 96'd0};
        div_dvs = {{(DVS_W-32){1'b0}}, bw_r};
        div_steps = 8'd32;
      end
      DC_BIN_RD: rd_addr = {row_r, qb[BIN_W-1:0]};
      DC_BIN_WR: begin
        wr_en = 1'b1;
        wr_addr = {row_r, qb[BIN_W-1:0]};
        wr_data = bin_sum[32] ? 32'hFFFFFFFF : bin_sum[31:0];
      end
      DC_MUL_MEAN: begin
        mul_start = 1'b1;
        mul_a = {32'd0, bw_r};
        mul_b = {14'd0, mean_num};
      end
      DC_DIV_MEAN: begin
        div_start = 1'b1;
        div_dvd = mul_p;
        div_dvs = {{(DVS_W-41){1'b0}}, tw_r, 1'b0};
      end
      DC_SET_MEAN: begin
        mul_start = 1'b1;
        mul_a = {8'd0, s2_r};
        mul_b = {24'd0, tw_r};
      end
      DC_MUL_S1S1: begin
        mul_start = 1'b1;
        mul_a = {16'd0, s1_r};
        mul_b = {16'd0, s1_r};
      end
      DC_DIV_V1: begin
        div_start = 1'b1;
        div_dvd = (x_r - mul_p) << 32;
      end
      DC_DIV_V2: begin
        div_start = 1'b1;
        div_dvd = div_q;
      end
      DC_MUL_BW2: begin
        mul_start = 1'b1;
        mul_a = {32'd0, bw_r};
        mul_b = {32'd0, bw_r};
      end
      DC_MUL_VAR: begin
        mul_start = 1'b1;
        mul_a = mul_p[63:0];
        mul_b = x_r[63:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_r <= '0;
      bw_r <= 32'd65536;
      biu_r <= NUSE_W'(256);
      clr_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_RANGE_LOW:   rl_r <= cfg_val;
          CFG_BIN_WIDTH:   bw_r <= cfg_val;
          CFG_BINS_IN_USE: biu_r <= cfg_val[NUSE_W-1:0];
          default: ;
        endcase
      end
      if (cmd == DC_CLR_STEP) clr_r <= clr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      DC_LOAD: begin
        row_r <= in_row;
        smp_r <= in_sample;
        wgt_r <= in_weight;
        st_r <= ST_OK;
        sum_r <= '0;
        mean_r <= '0;
        var_r <= '0;
      end
      DC_RES_UNDER: st_r <= ST_UNDERFLOW;
      DC_RES_OVER:  st_r <= ST_OVERFLOW;
      DC_STAT_INIT: begin
        idx_r <= '0;
        tw_r <= '0;
        s1_r <= '0;
        s2_r <= '0;
      end
      DC_WALK_M1: begin
        w_r <= rd_r;
        p1_r <= rd_r * idx_r;
      end
      DC_WALK_M2: p2_r <= p1_r * idx_r;
      DC_WALK_ACC: begin
        tw_r <= tw_r + {8'd0, w_r};
        s1_r <= s1_r + {8'd0, p1_r};
        s2_r <= s2_r + {8'd0, p2_r};
        idx_r <= idx_r + BIN_W'(1);
      end
      DC_SET_MEAN: mean_r <= mean_sat;
      DC_MUL_S1S1: x_r <= mul_p;
      DC_MUL_BW2:  x_r <= div_q;
      DC_SET_VAR: begin
        var_r <= var_sat;
        sum_r <= tw_r;
      end
      default: ;
    endcase
  end

  assign res_status = st_r;
  assign res_sum = sum_r;
  assign res_mean = mean_r;
  assign res_var = var_r;
endmodule

// ===== src/whm_ctrl.sv =====
// Controller state machine that sequences the datapath for each item.
module whm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [1:0]                 in_op,
  input  logic [whm_pkg::ROW_W-1:0]  in_row,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  whm_pkg::dp_status_t        sts,
  output whm_pkg::dp_cmd_t           cmd
);
  import whm_pkg::*;

  state_t state_r, state_nxt;
  logic   row_bad;

  assign row_bad = ({1'b0, in_row} >= (ROW_W+1)'(ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = DC_NONE;
    unique case (state_r)
      S_INIT: begin
        cmd = DC_CLR_STEP;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = DC_LOAD;
          unique case (op_t'(in_op))
            OP_CLEAR: state_nxt = S_CLR;
            OP_ADD:   state_nxt = row_bad ? S_RESP : S_BCHK;
            OP_STATS: state_nxt = row_bad ? S_RESP : S_SINIT;
            default:  state_nxt = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        cmd = DC_CLR_STEP;
        if (sts.clr_last) state_nxt = S_RESP;
      end
      S_BCHK: begin
        priority if (sts.d_neg) begin
          cmd = DC_RES_UNDER;
          state_nxt = S_RESP;
        end else if (sts.bw_zero) begin
          cmd = DC_RES_OVER;
          state_nxt = S_RESP;
        end else begin
          cmd = DC_BIN_DIV;
          state_nxt = S_BDIV;
        end
      end
      S_BDIV: begin
        if (sts.div_done) begin
          if (sts.ix_over) begin
            cmd = DC_RES_OVER;
            state_nxt = S_RESP;
          end else begin
            cmd = DC_BIN_RD;
            state_nxt = S_BWR;
          end
        end
      end
      S_BWR: begin
        cmd = DC_BIN_WR;
        state_nxt = S_RESP;
      end
      S_SINIT: begin
        cmd = DC_STAT_INIT;
        state_nxt = sts.n_zero ? S_RESP : S_WRD;
      end
      S_WRD: begin
        cmd = DC_WALK_RD;
        state_nxt = S_WM1;
      end
      S_WM1: begin
        cmd = DC_WALK_M1;
        state_nxt = S_WM2;
      end
      S_WM2: begin
        cmd = DC_WALK_M2;
        state_nxt = S_WACC;
      end
      S_WACC: begin
        cmd = DC_WALK_ACC;
        state_nxt = sts.last_bin ? S_FIN : S_WRD;
      end
      S_FIN: begin
        if (sts.tw_zero) begin
          state_nxt = S_RESP;
        end else begin
          cmd = DC_MUL_MEAN;
          state_nxt = S_MMUL;
        end
      end
      S_MMUL: if (sts.mul_done) begin
        cmd = DC_DIV_MEAN;
        state_nxt = S_MDIV;
      end
      S_MDIV: if (sts.div_done) begin
        cmd = DC_SET_MEAN;
        state_nxt = S_VMUL1;
      end
      S_VMUL1: if (sts.mul_done) begin
        cmd = DC_MUL_S1S1;
        state_nxt = S_VMUL2;
      end
      S_VMUL2: if (sts.mul_done) begin
        cmd = DC_DIV_V1;
        state_nxt = S_VDIV1;
      end
      S_VDIV1: if (sts.div_done) begin
        cmd = DC_DIV_V2;
        state_nxt = S_VDIV2;
      end
      S_VDIV2: if (sts.div_done) begin
        cmd = DC_MUL_BW2;
        state_nxt = S_VMUL3;
      end
      S_VMUL3: if (sts.mul_done) begin
        cmd = DC_MUL_VAR;
        state_nxt = S_VMUL4;
      end
      S_VMUL4: if (sts.mul_done) begin
        cmd = DC_SET_VAR;
        state_nxt = S_RESP;
      end
      S_RESP: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);
endmodule

// ===== src/weighted_histogram_moments_core.sv =====
// Add sample: a sample that lands in a bin waits for the 32-step bin divider, then its bin is
// read and written back; an underflow or a zero bin width answers straight from the bin check.
// Statistics: a walk over the bins in use (read, two multiply steps and accumulate per bin),
// then shared multiplier and 128-step divider work for mean and variance.
// Clear all bins: one memory entry per cycle. One item at a time.
// Reset is synchronous; afterwards a clearing pass over every bin entry runs with in_tready low.
module weighted_histogram_moments_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [55:0]   in_tdata,   // row[1:0], sample_value[33:2], weight[49:34], zero
  input  logic [1:0]    in_tuser,   // op[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [119:0]  out_tdata,  // sum_weights[39:0], mean[71:40], variance[119:72]
  output logic [1:0]    out_tuser,  // status[1:0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import whm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  logic [39:0] res_sum;
  logic [31:0] res_mean;
  logic [47:0] res_var;

  assign cfg_ready = 1'b1;

  whm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_op(in_tuser), .in_row(in_tdata[ROW_W-1:0]),
    .in_ready(in_tready), .out_valid(out_tvalid), .out_ready(out_tready),
    .sts(sts), .cmd(cmd)
  );

  whm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_row(in_tdata[1:0]), .in_sample(in_tdata[33:2]), .in_weight(in_tdata[49:34]),
    .cfg_we(cfg_valid & cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .sts(sts), .res_status(out_tuser), .res_sum(res_sum), .res_mean(res_mean),
    .res_var(res_var)
  );

  assign out_tdata = {res_var, res_mean, res_sum};
endmodule

// ===== tb/whm_checker.sv =====
// Checker for the weighted histogram core: predicts each result from the transfers it sees.
module whm_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [55:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import whm_pkg::*;

  localparam logic [63:0] SAT40 = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] SAT48 = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  status;
    logic [39:0] sum_w;
    logic [31:0] mean;
    logic [47:0] var_q;
  } moments_t;

  moments_t    expected_q[$];
  logic [31:0] hist[0:ROWS-1][0:BINS-1];
  logic [31:0] low_edge;
  logic [31:0] bin_w;
  logic [8:0]  n_cfg;

  assign pending = expected_q.size();

  function automatic int used_bins();
    return (n_cfg > BINS) ? BINS : int'(n_cfg);
  endfunction

  function automatic moments_t bin_sample(logic [1:0] row, logic [31:0] x, logic [15:0] w);
    moments_t res;
    longint   d;
    longint   ix;
    res = '{ST_OK, '0, '0, '0};
    d = longint'($signed(x)) - longint'($signed(low_edge));
    if (d < 0) begin
      res.status = ST_UNDERFLOW;
    end else if (bin_w == 0) begin
      res.status = ST_OVERFLOW;
    end else begin
      ix = d / longint'({32'd0, bin_w});
      if (ix >= used_bins()) begin
        res.status = ST_OVERFLOW;
      end else if ({1'b0, hist[row][ix]} + w > 33'hFFFF_FFFF) begin
        hist[row][ix] = 32'hFFFF_FFFF;
      end else begin
        hist[row][ix] = hist[row][ix] + w;
      end
    end
    return res;
  endfunction

  function automatic moments_t row_moments(logic [1:0] row);
    moments_t     res;
    logic [255:0] tw, s1, s2, bw, q, v, t, vf, p;
    longint       m;
    res = '{ST_OK, '0, '0, '0};
    tw = '0; s1 = '0; s2 = '0;
    for (int i = 0; i < used_bins(); i++) begin
      tw = tw + hist[row][i];
      s1 = s1 + hist[row][i] * i;
      s2 = s2 + hist[row][i] * i * i;
    end
    if (tw == 0) return res;
    res.sum_w = (tw > SAT40) ? SAT40[39:0] : tw[39:0];
    bw = {224'd0, bin_w};
    q = (bw * (2 * s1 + tw)) / (2 * tw);
    m = longint'($signed(low_edge)) + longint'(q[63:0]);
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    res.mean = m[31:0];
    v = s2 * tw - s1 * s1;
    t = (v << 32) / tw;
    vf = t / tw;
    p = (bw * bw * {192'd0, vf[63:0]}) >> 48;
    res.var_q = (p > SAT48) ? SAT48[47:0] : p[47:0];
    return res;
  endfunction

  function automatic moments_t predict(op_t op, logic [1:0] row, logic [31:0] x, logic [15:0] w);
    moments_t res;
    res = '{ST_OK, '0, '0, '0};
    case (op)
      OP_ADD:   res = bin_sample(row, x, w);
      OP_STATS: res = row_moments(row);
      OP_CLEAR: begin
        for (int r = 0; r < ROWS; r++)
          for (int b = 0; b < BINS; b++) hist[r][b] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    moments_t e;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++)
        for (int b = 0; b < BINS; b++) hist[r][b] = '0;
      low_edge = '0;
      bin_w = 32'd65536;
      n_cfg = 9'd256;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RANGE_LOW:   low_edge = cfg_data;
          CFG_BIN_WIDTH:   bin_w = cfg_data;
          CFG_BINS_IN_USE: n_cfg = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict(op_t'(in_tuser), in_tdata[1:0], in_tdata[33:2],
                                     in_tdata[49:34]));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no expectation pending");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_tuser !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_tuser);
            errs++;
          end
          if (out_tdata[39:0] !== e.sum_w) begin
            $error("sum_weights: expected %0h, actual %0h", e.sum_w, out_tdata[39:0]);
            errs++;
          end
          if (out_tdata[71:40] !== e.mean) begin
            $error("mean: expected %0h, actual %0h", e.mean, out_tdata[71:40]);
            errs++;
          end
          if (out_tdata[119:72] !== e.var_q) begin
            $error("variance: expected %0h, actual %0h", e.var_q, out_tdata[119:72]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== tb/tb_weighted_histogram_moments_core.sv =====
// Top of the testbench for the weighted histogram core: stimulus, stalls and verdict.
module tb_weighted_histogram_moments_core;
  import whm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count;
  int           pending;

  // Stimulus-side copy of the settings, used only to aim samples at real bins.
  logic [31:0]  cur_low;
  logic [31:0]  cur_bw;
  int           cur_n;
  logic         idle_on;
  int           stall_left;
  int           quiet_cycles;

  weighted_histogram_moments_core u_top (.*);

  whm_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(5) == 0) begin
      stall_left <= $urandom_range(14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge; tvalid stays high into the next item.
  task automatic send_item(op_t op, logic [1:0] row, logic [31:0] x, logic [15:0] w);
    if (idle_on && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, w, x, row};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(logic [31:0] low, logic [31:0] bw, logic [8:0] n);
    wait_idle();
    write_reg(CFG_RANGE_LOW, low);
    write_reg(CFG_BIN_WIDTH, bw);
    write_reg(CFG_BINS_IN_USE, {23'd0, n});
    cfg_valid <= 1'b0;
    cur_low = low;
    cur_bw  = bw;
    cur_n   = (n > BINS) ? BINS : int'(n);
  endtask

  // Mostly samples that land in a used bin; the rest straddle the range edges or are noise.
  function automatic logic [31:0] pick_sample();
    longint v;
    int     sel;
    sel = $urandom_range(99);
    if (cur_n == 0 || cur_bw == 0 || sel >= 90) return $urandom;
    if (sel < 70)
      v = longint'($signed(cur_low)) + longint'($urandom_range(cur_n - 1)) * cur_bw
          + longint'({$urandom} % cur_bw);
    else if (sel < 80)
      v = longint'($signed(cur_low)) - longint'($urandom_range(1, 1000));
    else
      v = longint'($signed(cur_low)) + longint'(cur_n) * cur_bw
          + longint'($urandom_range(0, 1000));
    if (v > 64'sd2147483647 || v < -64'sd2147483648) return $urandom;
    return v[31:0];
  endfunction

  task automatic random_items(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) idle_on = ($urandom_range(3) != 0);
      sel = $urandom_range(99);
      if (sel < 80)
        send_item(OP_ADD, 2'($urandom), pick_sample(),
                  ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
      else if (sel < 92)
        send_item(OP_STATS, 2'($urandom), $urandom, 16'($urandom));
      else if (sel < 94)
        send_item(OP_CLEAR, 2'($urandom), $urandom, 16'($urandom));
      else
        send_item(OP_NONE, 2'($urandom), $urandom, 16'($urandom));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_ADD;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_RANGE_LOW;
    cfg_data   = '0;
    idle_on    = 1'b1;
    cur_low    = '0;
    cur_bw     = 32'd65536;
    cur_n      = BINS;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every op, empty rows and op three.
    send_item(OP_STATS, 2'd0, '0, '0);
    send_item(OP_ADD, 2'd0, 32'h8000_0000, 16'hFFFF);
    send_item(OP_ADD, 2'd1, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(OP_ADD, 2'd2, 32'h0000_0000, 16'h0000);
    send_item(OP_ADD, 2'd3, 32'h00FF_FFFF, 16'hFFFF);
    send_item(OP_ADD, 2'd3, 32'h0100_0000, 16'h0001);
    send_item(OP_ADD, 2'd0, 32'h0000_8000, 16'h1234);
    send_item(OP_ADD, 2'd0, 32'h00FF_0000, 16'hFFFF);
    send_item(OP_ADD, 2'd1, 32'h0001_0000, 16'h8000);
    for (int r = 0; r < ROWS; r++) send_item(OP_STATS, 2'(r), 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_NONE, 2'd3, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_CLEAR, 2'd0, '0, '0);
    send_item(OP_STATS, 2'd3, '0, '0);
    random_items(230);

    // Narrowest settings: one bin of width one at the bottom of the range.
    configure(32'h8000_0000, 32'd1, 9'd1);
    send_item(OP_ADD, 2'd0, 32'h8000_0000, 16'hFFFF);
    send_item(OP_ADD, 2'd0, 32'h8000_0001, 16'h0001);
    send_item(OP_STATS, 2'd0, '0, '0);
    random_items(200);

    // Widest bins near the top of the range, where the mean saturates.
    configure(32'h7FFF_0000, 32'hFFFF_FFFF, 9'd256);
    send_item(OP_ADD, 2'd2, 32'h7FFF_FFFF, 16'hFFFF);
    send_item(OP_STATS, 2'd2, '0, '0);
    random_items(200);

    // Zero width and zero bins in use: everything above the edge overflows.
    configure(32'hFFFF_0000, 32'd0, 9'd5);
    random_items(120);
    configure(32'h0000_0000, 32'd65536, 9'd0);
    random_items(120);

    configure($urandom, 32'h0000_4000, 9'd16);
    random_items(260);

    // Count above the bin array, then shrink to show that upper bins are kept.
    configure(32'hFF80_0000, 32'h0001_0000, 9'd300);
    random_items(250);
    configure(32'hFF80_0000, 32'h0001_0000, 9'd8);
    random_items(150);
    configure(32'hFF80_0000, 32'h0001_0000, 9'd256);
    for (int r = 0; r < ROWS; r++) send_item(OP_STATS, 2'(r), '0, '0);

    configure($urandom, $urandom_range(1, 32'h0004_0000), 9'($urandom_range(1, 64)));
    random_items(150);
    idle_on = 1'b0;
    random_items(80);

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/whm_pkg.sv
src/whm_mul.sv
src/whm_div.sv
src/whm_datapath.sv
src/whm_ctrl.sv
src/weighted_histogram_moments_core.sv
tb/whm_checker.sv
tb/tb_weighted_histogram_moments_core.sv
